// ===== rtl/srp_pkg.sv =====
package srp_pkg;

    localparam int SRP_MAX_SEGMENTS = 64;
    localparam int FW = 13;

    localparam logic [FW-1:0] AREA_RESET = 13'd1024;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] CFG_AREA_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_AREA_HEIGHT = 2'd1;

    localparam logic REQ_PACK  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic [FW-1:0] x;
        logic [FW-1:0] h;
        logic [FW-1:0] w;
    } seg_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_INIT, CMD_LOAD, CMD_CLEAR, CMD_NOFIT, CMD_FULL,
        CMD_SCAN, CMD_NEXTI, CMD_BEGIN, CMD_ADV, CMD_HIT, CMD_RDL,
        CMD_LATL, CMD_PLAN, CMD_MVRD, CMD_MVWR, CMD_PUT, CMD_EMIT
    } dp_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic zero_size;
        logic x_fail;
        logic h_fail;
        logic fit_done;
        logic j_end;
        logic i_last;
        logic found;
        logic full;
        logic mv_any;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/srp_ctrl.sv =====
module srp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  srp_pkg::dp_status_t st,
    output srp_pkg::dp_cmd_t   cmd,
    output logic               s_tready
);
    import srp_pkg::*;

    typedef enum logic [12:0] {
        S_INIT   = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_START  = 13'b0000000000100,
        S_CHK    = 13'b0000000001000,
        S_STEP   = 13'b0000000010000,
        S_DECIDE = 13'b0000000100000,
        S_RDL    = 13'b0000001000000,
        S_RDR    = 13'b0000010000000,
        S_MVRD   = 13'b0000100000000,
        S_MVWR   = 13'b0001000000000,
        S_PUT    = 13'b0010000000000,
        S_DONE   = 13'b0100000000000,
        S_SPARE  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_INIT: begin
                cmd        = CMD_INIT;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd        = CMD_LOAD;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (st.is_clear) begin
                    cmd        = CMD_CLEAR;
                    state_next = S_DONE;
                end else if (st.zero_size) begin
                    cmd        = CMD_NOFIT;
                    state_next = S_DONE;
                end else begin
                    cmd        = CMD_SCAN;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (st.x_fail) begin
                    cmd        = CMD_NEXTI;
                    state_next = st.i_last ? S_DECIDE : S_CHK;
                end else begin
                    cmd        = CMD_BEGIN;
                    state_next = S_STEP;
                end
            end
            S_STEP: begin
                if (st.h_fail) begin
                    cmd        = CMD_NEXTI;
                    state_next = st.i_last ? S_DECIDE : S_CHK;
                end else if (st.fit_done) begin
                    cmd        = CMD_HIT;
                    state_next = st.i_last ? S_DECIDE : S_CHK;
                end else if (st.j_end) begin
                    cmd        = CMD_NEXTI;
                    state_next = st.i_last ? S_DECIDE : S_CHK;
                end else begin
                    cmd        = CMD_ADV;
                    state_next = S_STEP;
                end
            end
            S_DECIDE: begin
                if (!st.found) begin
                    cmd        = CMD_NOFIT;
                    state_next = S_DONE;
                end else if (st.full) begin
                    cmd        = CMD_FULL;
                    state_next = S_DONE;
                end else begin
                    cmd        = CMD_RDL;
                    state_next = S_RDL;
                end
            end
            S_RDL: begin
                cmd        = CMD_LATL;
                state_next = S_RDR;
            end
            S_RDR: begin
                cmd        = CMD_PLAN;
                state_next = S_MVRD;
            end
            S_MVRD: begin
                if (st.mv_any) begin
                    cmd        = CMD_MVRD;
                    state_next = S_MVWR;
                end else begin
                    state_next = S_PUT;
                end
            end
            S_MVWR: begin
                cmd        = CMD_MVWR;
                state_next = S_MVRD;
            end
            S_PUT: begin
                cmd        = CMD_PUT;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd        = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

// ===== rtl/srp_dp.sv =====
module srp_dp #(
    parameter int MAX_SEGMENTS = srp_pkg::SRP_MAX_SEGMENTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  srp_pkg::dp_cmd_t    cmd,
    output srp_pkg::dp_status_t st,
    input  logic [31:0]         s_tdata,
    input  logic [0:0]          s_tuser,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,
    output logic [1:0]          m_tuser
);
    import srp_pkg::*;

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    seg_t seg_mem [MAX_SEGMENTS];
    seg_t rd_data_reg;
    logic [IW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    seg_t          wr_data;

    logic [FW-1:0] aw_reg, ah_reg;
    logic          m_valid_reg;
    logic [31:0]   m_data_reg;
    logic [1:0]    m_user_reg;

    logic          op_reg;
    logic [FW-1:0] rw_reg, rh_reg;
    logic [CW-1:0] count_reg, i_reg, j_reg;
    logic [FW-1:0] y_reg, left_reg, wi_reg, xi_reg;
    logic          found_reg;
    logic [CW-1:0] best_reg, best_e_reg;
    logic [FW-1:0] best_y_reg, best_w_reg, best_x_reg, best_cover_reg;
    logic          best_part_reg;
    seg_t          left_seg_reg;
    logic          ml_reg, mr_reg, back_reg;
    logic [FW-1:0] wr_w_reg;
    logic [CW-1:0] d_reg, s_reg, k_reg, mv_cnt_reg, newcnt_reg;
    logic [1:0]    res_status_reg;
    logic [FW-1:0] res_x_reg, res_y_reg;

    seg_t          rd;
    logic [FW-1:0] y_max, nh;
    logic [CW-1:0] i_inc, j_inc, best_dec, d_next, s_next, k_dst;
    logic          better, ml_next, mr_next;

    assign rd       = rd_data_reg;
    assign i_inc    = i_reg + 1'b1;
    assign j_inc    = j_reg + 1'b1;
    assign best_dec = best_reg - 1'b1;
    assign y_max    = (rd.h > y_reg) ? rd.h : y_reg;
    assign nh       = best_y_reg + rh_reg;
    assign better   = !found_reg || (y_max < best_y_reg) ||
                      ((y_max == best_y_reg) && (wi_reg < best_w_reg));
    assign ml_next  = (best_reg != '0) && (left_seg_reg.h == nh);
    assign mr_next  = (best_e_reg < count_reg) && (rd.h == nh);
    assign d_next   = best_reg + CW'(!ml_next);
    assign s_next   = best_e_reg + CW'(mr_next);
    assign k_dst    = k_reg + d_reg - s_reg;

    assign st.is_clear  = (op_reg == REQ_CLEAR);
    assign st.zero_size = (rw_reg == '0) || (rh_reg == '0);
    assign st.x_fail    = ({1'b0, rd.x} + {1'b0, rw_reg}) > {1'b0, aw_reg};
    assign st.h_fail    = ({1'b0, y_max} + {1'b0, rh_reg}) > {1'b0, ah_reg};
    assign st.fit_done  = (left_reg <= rd.w);
    assign st.j_end     = (j_inc >= count_reg);
    assign st.i_last    = (i_inc >= count_reg);
    assign st.found     = found_reg;
    assign st.full      = (count_reg >= CW'(MAX_SEGMENTS));
    assign st.mv_any    = (mv_cnt_reg != '0);
    assign st.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        case (cmd)
            CMD_NEXTI, CMD_HIT: rd_addr = i_inc[IW-1:0];
            CMD_BEGIN:          rd_addr = i_reg[IW-1:0];
            CMD_ADV:            rd_addr = j_inc[IW-1:0];
            CMD_RDL:            rd_addr = best_dec[IW-1:0];
            CMD_LATL:           rd_addr = best_e_reg[IW-1:0];
            CMD_MVRD:           rd_addr = k_reg[IW-1:0];
            CMD_INIT: begin
                wr_en   = 1'b1;
                wr_data = '{x: '0, h: '0, w: AREA_RESET};
            end
            CMD_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = '{x: '0, h: '0, w: aw_reg};
            end
            CMD_MVWR: begin
                wr_en   = 1'b1;
                wr_addr = k_dst[IW-1:0];
                wr_data = rd;
                // the partly covered segment keeps only its uncovered right part
                if ((k_reg == s_reg) && best_part_reg) begin
                    wr_data.x = rd.x + best_cover_reg;
                    wr_data.w = rd.w - best_cover_reg;
                end
            end
            CMD_PUT: begin
                wr_en     = 1'b1;
                wr_addr   = ml_reg ? best_dec[IW-1:0] : best_reg[IW-1:0];
                wr_data.x = ml_reg ? left_seg_reg.x : best_x_reg;
                wr_data.h = nh;
                wr_data.w = (ml_reg ? left_seg_reg.w : '0) + rw_reg +
                            (mr_reg ? wr_w_reg : '0);
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= seg_mem[rd_addr];
        if (wr_en) begin
            seg_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aw_reg      <= AREA_RESET;
            ah_reg      <= AREA_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && (cfg_index == CFG_AREA_WIDTH)) begin
                aw_reg <= cfg_data[FW-1:0];
            end
            if (cfg_valid && (cfg_index == CFG_AREA_HEIGHT)) begin
                ah_reg <= cfg_data[FW-1:0];
            end
            if (cmd == CMD_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_INIT: begin
                count_reg <= CW'(1);
            end
            CMD_LOAD: begin
                op_reg <= s_tuser[0];
                rw_reg <= s_tdata[FW-1:0];
                rh_reg <= s_tdata[2*FW-1:FW];
            end
            CMD_CLEAR: begin
                count_reg      <= CW'(1);
                res_status_reg <= ST_OK;
                res_x_reg      <= '0;
                res_y_reg      <= '0;
            end
            CMD_NOFIT: begin
                res_status_reg <= ST_NOFIT;
                res_x_reg      <= '0;
                res_y_reg      <= '0;
            end
            CMD_FULL: begin
                res_status_reg <= ST_FULL;
                res_x_reg      <= '0;
                res_y_reg      <= '0;
            end
            CMD_SCAN: begin
                i_reg     <= '0;
                found_reg <= 1'b0;
            end
            CMD_NEXTI: begin
                i_reg <= i_inc;
            end
            CMD_BEGIN: begin
                y_reg    <= rd.h;
                left_reg <= rw_reg;
                j_reg    <= i_reg;
                wi_reg   <= rd.w;
                xi_reg   <= rd.x;
            end
            CMD_ADV: begin
                y_reg    <= y_max;
                left_reg <= left_reg - rd.w;
                j_reg    <= j_inc;
            end
            CMD_HIT: begin
                i_reg <= i_inc;
                if (better) begin
                    found_reg      <= 1'b1;
                    best_reg       <= i_reg;
                    best_y_reg     <= y_max;
                    best_w_reg     <= wi_reg;
                    best_x_reg     <= xi_reg;
                    best_part_reg  <= (left_reg < rd.w);
                    best_e_reg     <= (left_reg < rd.w) ? j_reg : j_inc;
                    best_cover_reg <= left_reg;
                end
            end
            CMD_LATL: begin
                left_seg_reg <= rd;
            end
            CMD_PLAN: begin
                ml_reg     <= ml_next;
                mr_reg     <= mr_next;
                wr_w_reg   <= rd.w;
                d_reg      <= d_next;
                s_reg      <= s_next;
                back_reg   <= (d_next > s_next);
                // move the tail from its end when it grows, else from its start
                k_reg      <= (d_next > s_next) ? (count_reg - 1'b1) : s_next;
                mv_cnt_reg <= count_reg - s_next;
                newcnt_reg <= d_next + count_reg - s_next;
            end
            CMD_MVWR: begin
                k_reg      <= back_reg ? (k_reg - 1'b1) : (k_reg + 1'b1);
                mv_cnt_reg <= mv_cnt_reg - 1'b1;
            end
            CMD_PUT: begin
                count_reg      <= newcnt_reg;
                res_status_reg <= ST_OK;
                res_x_reg      <= best_x_reg;
                res_y_reg      <= best_y_reg;
            end
            CMD_EMIT: begin
                m_data_reg <= {6'd0, res_y_reg, res_x_reg};
                m_user_reg <= res_status_reg;
            end
            default: begin
                op_reg <= op_reg;
            end
        endcase
    end

endmodule

// ===== rtl/skyline_rect_packer_top.sv =====
// Skyline rectangle packer: lowest fit first, ties to the narrower start segment.
// Input channel s_*: one word per request. s_tuser[0] selects pack (0) or
// clear (1); s_tdata carries rect_width and rect_height. Output channel m_*:
// one word per request, m_tuser holds the status (placed/cleared, no fit,
// table full) and m_tdata the placed position, zero unless placed.
// Configuration channel cfg_*: index 0 sets area_width, index 1 area_height;
// it is always ready and must be written only while no request is in flight.
// A clear resets the skyline to one flat segment. A pack scans every segment
// as a start point, one segment read per cycle from the segment memory, then
// moves the tail segments on insert or merge, with a read and a write per
// segment moved, and writes the new segment.
// After reset the INIT state writes the flat initial segment, then s_tready rises.
// A finished result sits in the output register; the next request is taken
// while it waits, and that request holds at its end until m_tready frees it.
module skyline_rect_packer_top #(
    parameter int MAX_SEGMENTS = srp_pkg::SRP_MAX_SEGMENTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [12:0] rect_width, [25:13] rect_height, rest zero
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [12:0] pos_x, [25:13] pos_y, rest zero
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import srp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    srp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .st       (st),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    srp_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== test/skyline_rect_packer_top_tb.sv =====
`timescale 1ns / 1ps

module skyline_rect_packer_top_tb;
    import srp_pkg::*;

    localparam int NSEG = SRP_MAX_SEGMENTS;
    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    typedef struct {
        logic          op;
        logic [FW-1:0] rw;
        logic [FW-1:0] rh;
        bit            is_cfg;
        logic [1:0]    cidx;
        logic [15:0]   cval;
    } req_t;

    typedef struct {
        logic [1:0]    status;
        logic [FW-1:0] px;
        logic [FW-1:0] py;
    } place_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    skyline_rect_packer_top dut (.*);

    always #10 aclk = ~aclk;

    // skyline mirror
    int unsigned sx[NSEG], sh[NSEG], sw[NSEG];
    int unsigned nseg;
    int unsigned area_w, area_h;

    req_t   pending[$];
    place_t placements[$];
    int     errors = 0;
    longint cycles = 0;
    bit     in_taken = 0;
    bit     out_taken = 0;

    function automatic void reset_skyline();
        for (int i = 0; i < NSEG; i++) begin
            sx[i] = 0; sh[i] = 0; sw[i] = 0;
        end
        sw[0] = area_w;
        nseg = 1;
    endfunction

    function automatic bit lowest_fit(int unsigned s, int unsigned rw, int unsigned rh,
                                      output int unsigned y);
        int unsigned left;
        int unsigned j;
        left = rw;
        j = s;
        y = 0;
        if (sx[s] + rw > area_w) return 0;
        y = sh[s];
        while (left > 0) begin
            if (j >= nseg) return 0;
            if (sh[j] > y) y = sh[j];
            if (y + rh > area_h) return 0;
            left = (left > sw[j]) ? left - sw[j] : 0;
            j++;
        end
        return 1;
    endfunction

    function automatic place_t pack_rect(logic op, int unsigned rw, int unsigned rh);
        place_t r;
        bit found;
        int unsigned best, best_y, best_w, y, i, j, px, pe, shr;
        r.status = ST_OK; r.px = '0; r.py = '0;
        found = 0; best = 0; best_y = 0; best_w = 0;
        if (op == REQ_CLEAR) begin
            reset_skyline();
            return r;
        end
        if (rw == 0 || rh == 0) begin
            r.status = ST_NOFIT;
            return r;
        end
        for (i = 0; i < nseg; i++)
            if (lowest_fit(i, rw, rh, y))
                if (!found || y < best_y || (y == best_y && sw[i] < best_w)) begin
                    found = 1; best = i; best_y = y; best_w = sw[i];
                end
        if (!found) begin
            r.status = ST_NOFIT;
            return r;
        end
        if (nseg >= NSEG) begin
            r.status = ST_FULL;
            return r;
        end
        px = sx[best];
        for (i = nseg; i > best; i--) begin
            sx[i] = sx[i-1]; sh[i] = sh[i-1]; sw[i] = sw[i-1];
        end
        sx[best] = px; sh[best] = best_y + rh; sw[best] = rw;
        nseg++;
        // trim segments hidden under the new one
        i = best + 1;
        while (i < nseg) begin
            pe = sx[i-1] + sw[i-1];
            if (sx[i] >= pe) break;
            shr = pe - sx[i];
            sx[i] += shr;
            if (sw[i] <= shr) begin
                for (j = i; j + 1 < nseg; j++) begin
                    sx[j] = sx[j+1]; sh[j] = sh[j+1]; sw[j] = sw[j+1];
                end
                nseg--;
            end else begin
                sw[i] -= shr;
                break;
            end
        end
        j = 0;
        for (i = 1; i < nseg; i++) begin
            if (sh[i] == sh[j]) sw[j] += sw[i];
            else begin
                j++;
                sx[j] = sx[i]; sh[j] = sh[i]; sw[j] = sw[i];
            end
        end
        nseg = j + 1;
        for (i = nseg; i < NSEG; i++) begin
            sx[i] = 0; sh[i] = 0; sw[i] = 0;
        end
        r.px = px[FW-1:0];
        r.py = best_y[FW-1:0];
        return r;
    endfunction

    function automatic void add_pack(int unsigned rw, int unsigned rh);
        req_t q;
        q.op = REQ_PACK; q.rw = rw[FW-1:0]; q.rh = rh[FW-1:0];
        q.is_cfg = 0; q.cidx = '0; q.cval = '0;
        pending = {pending, q};
    endfunction

    function automatic void add_clear();
        req_t q;
        q.op = REQ_CLEAR; q.rw = FW'($urandom); q.rh = FW'($urandom);
        q.is_cfg = 0; q.cidx = '0; q.cval = '0;
        pending = {pending, q};
    endfunction

    function automatic void add_cfg(logic [1:0] idx, int unsigned v);
        req_t q;
        q.op = REQ_PACK; q.rw = '0; q.rh = '0;
        q.is_cfg = 1; q.cidx = idx; q.cval = v[15:0];
        pending = {pending, q};
    endfunction

    // record the handshakes of the last rising edge
    always @(posedge aclk) begin
        in_taken  <= s_tvalid && s_tready;
        out_taken <= m_tvalid && m_tready;
    end

    // driver
    int  s_wait = 0;
    int  drain = 0;
    always @(negedge aclk) begin
        req_t   q;
        place_t p;
        if (aresetn) begin
            if (cfg_valid) begin
                cfg_valid <= 1'b0;
            end else if (s_tvalid && !in_taken) begin
                // hold the word
            end else if (pending.size() > 0 && pending[0].is_cfg) begin
                s_tvalid <= 1'b0;
                // wait for the block to drain before a register write
                if (placements.size() == 0 && !s_tvalid) begin
                    if (drain < 300) drain <= drain + 1;
                    else begin
                        drain <= 0;
                        q = pending.pop_front();
                        cfg_valid <= 1'b1;
                        cfg_index <= q.cidx;
                        cfg_data  <= q.cval;
                        if (q.cidx == CFG_AREA_WIDTH) area_w = q.cval & 16'h1FFF;
                        else area_h = q.cval & 16'h1FFF;
                    end
                end
            end else if (s_wait > 0) begin
                s_tvalid <= 1'b0;
                s_wait <= s_wait - 1;
            end else if (pending.size() > 0) begin
                q = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= q.op;
                s_tdata  <= {6'd0, q.rh, q.rw};
                p = pack_rect(q.op, q.rw, q.rh);
                placements = {placements, p};
                s_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink pacing
    int m_wait = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_taken) begin
                m_wait = $urandom_range(0, 4);
                m_tready <= (m_wait == 0);
            end else if (m_wait > 0) begin
                m_wait = m_wait - 1;
                m_tready <= (m_wait == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        place_t e;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (placements.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: status %0d x %0d y %0d",
                             m_tuser, m_tdata[12:0], m_tdata[25:13]);
            end else begin
                e = placements.pop_front();
                if (m_tuser !== e.status || m_tdata[12:0] !== e.px
                    || m_tdata[25:13] !== e.py || m_tdata[31:26] !== 6'd0) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp st %0d x %0d y %0d, got st %0d x %0d y %0d",
                                 e.status, e.px, e.py,
                                 m_tuser, m_tdata[12:0], m_tdata[25:13]);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int unsigned small_dim(int unsigned lim);
        return $urandom_range(1, (lim < 64) ? lim : 64);
    endfunction

    initial begin
        int unsigned w, h;
        area_w = AREA_RESET;
        area_h = AREA_RESET;
        reset_skyline();

        // directed
        add_pack(4096, 4096);
        add_pack(1025, 1);
        add_pack(1, 1025);
        add_pack(0, 5);
        add_pack(5, 0);
        add_pack(1024, 1);
        add_pack(100, 20);
        add_pack(50, 20);
        add_pack(1, 1);
        add_pack(8191, 8191);
        add_clear();
        add_pack(512, 1023);
        add_pack(512, 1024);
        add_pack(1, 1);
        add_clear();
        // fill the table with a staircase
        for (int i = 0; i < 70; i++) add_pack(1, 70 - i);
        add_pack(1, 1);
        add_pack(2000, 1);
        add_clear();

        add_cfg(CFG_AREA_WIDTH, 4096);
        add_cfg(CFG_AREA_HEIGHT, 4096);
        add_pack(4096, 4096);
        add_clear();
        add_cfg(CFG_AREA_WIDTH, 1);
        add_cfg(CFG_AREA_HEIGHT, 1);
        add_pack(1, 1);
        add_pack(1, 1);
        add_clear();
        add_pack(1, 1);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin w = 4096; h = 4096; end
                1: begin w = $urandom_range(16, 300); h = $urandom_range(16, 300); end
                2: begin w = 1024; h = 1024; end
                default: begin w = $urandom_range(1, 8191); h = $urandom_range(1, 8191); end
            endcase
            add_cfg(CFG_AREA_WIDTH, w);
            add_cfg(CFG_AREA_HEIGHT, h);
            add_clear();
            for (int k = 0; k < 104; k++) begin
                case ($urandom_range(0, 19))
                    0: add_clear();
                    1: add_pack($urandom_range(0, 8191), $urandom_range(0, 8191));
                    2: add_pack($urandom_range(1, 8), $urandom_range(1, 8));
                    default: add_pack(small_dim(w), small_dim(h));
                endcase
            end
        end

        // shrink the width under a live skyline
        add_cfg(CFG_AREA_WIDTH, 1024);
        add_cfg(CFG_AREA_HEIGHT, 1024);
        add_clear();
        for (int k = 0; k < 10; k++) add_pack($urandom_range(20, 200), $urandom_range(1, 50));
        add_cfg(CFG_AREA_WIDTH, 300);
        for (int k = 0; k < 10; k++) add_pack($urandom_range(1, 200), $urandom_range(1, 50));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_tvalid || cfg_valid || placements.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0 && placements.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
